>>> rtl/core/mkt_pkg.sv
// shared constants, tables and types for the musical key tracker
package mkt_pkg;

    localparam int BinWidthDefault = 32;

    localparam logic [15:0] ThreshReset = 16'd45875;
    localparam logic [15:0] GainReset   = 16'd655;
    localparam logic [15:0] ScaleReset  = 16'd655;
    localparam logic [15:0] WeightReset = 16'd3277;

    localparam logic [1:0] RegThresh = 2'd0;
    localparam logic [1:0] RegGain   = 2'd1;
    localparam logic [1:0] RegScale  = 2'd2;
    localparam logic [1:0] RegWeight = 2'd3;

    // semitone boundaries of the normalized octave, Q1.23
    function automatic logic [23:0] octave_bound(input logic [3:0] n);
        case (n)
            4'd0:    octave_bound = 24'd8824153;
            4'd1:    octave_bound = 24'd9348865;
            4'd2:    octave_bound = 24'd9904777;
            4'd3:    octave_bound = 24'd10493746;
            4'd4:    octave_bound = 24'd11117736;
            4'd5:    octave_bound = 24'd11778832;
            4'd6:    octave_bound = 24'd12479237;
            4'd7:    octave_bound = 24'd13221291;
            4'd8:    octave_bound = 24'd14007470;
            4'd9:    octave_bound = 24'd14840398;
            4'd10:   octave_bound = 24'd15722854;
            default: octave_bound = 24'd16657784;
        endcase
    endfunction

    // key profiles in hundredths
    function automatic logic [9:0] major_prof(input logic [3:0] n);
        case (n)
            4'd0:    major_prof = 10'd635;
            4'd1:    major_prof = 10'd223;
            4'd2:    major_prof = 10'd348;
            4'd3:    major_prof = 10'd233;
            4'd4:    major_prof = 10'd438;
            4'd5:    major_prof = 10'd409;
            4'd6:    major_prof = 10'd252;
            4'd7:    major_prof = 10'd519;
            4'd8:    major_prof = 10'd239;
            4'd9:    major_prof = 10'd366;
            4'd10:   major_prof = 10'd229;
            default: major_prof = 10'd288;
        endcase
    endfunction

    function automatic logic [9:0] minor_prof(input logic [3:0] n);
        case (n)
            4'd0:    minor_prof = 10'd633;
            4'd1:    minor_prof = 10'd268;
            4'd2:    minor_prof = 10'd352;
            4'd3:    minor_prof = 10'd538;
            4'd4:    minor_prof = 10'd260;
            4'd5:    minor_prof = 10'd353;
            4'd6:    minor_prof = 10'd254;
            4'd7:    minor_prof = 10'd475;
            4'd8:    minor_prof = 10'd398;
            4'd9:    minor_prof = 10'd269;
            4'd10:   minor_prof = 10'd334;
            default: minor_prof = 10'd317;
        endcase
    endfunction

    typedef struct packed {
        logic [15:0] thresh;
        logic [15:0] gain;
        logic [15:0] scale;
        logic [15:0] weight;
    } cfg_t;

endpackage

>>> rtl/core/mkt_if.sv
// valid/ready channel carrying one payload word
interface mkt_if #(parameter int W = 8) (input logic clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mkt_classify.sv
// pitch class finder: octave normalization then boundary count
module mkt_classify
    import mkt_pkg::*;
(
    input  logic [23:0] pitch,
    output logic [3:0]  pclass
);
    logic [23:0] norm;
    logic [3:0]  cnt;

    // leading-one normalization and boundary count
    always_comb
    begin
        norm = pitch;
        for (int s = 0; s < 24; s++)
        begin
            if (norm[23] == 1'b0)
            begin
                norm = {norm[22:0], 1'b0};
            end
        end
        cnt = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (norm >= octave_bound(4'(i)))
            begin
                cnt = cnt + 4'd1;
            end
        end
        pclass = (cnt == 4'd12) ? 4'd0 : cnt;
    end
endmodule

>>> rtl/core/mkt_engine.sv
// histogram memory, correlation sequencer and confidence update
module mkt_engine
    import mkt_pkg::*;
#(
    parameter int BIN_WIDTH = BinWidthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        start,
    input  logic [3:0]  pclass,
    input  logic [15:0] harm,
    output logic        busy,
    output logic        done,
    output logic [3:0]  tonic,
    output logic        minor,
    output logic [15:0] conf
);
    localparam int AccW = BIN_WIDTH + 14;

    // reciprocal of 100 in Q0.30, exact for quotients below the cap
    localparam logic [23:0] DivM = 24'd10737419;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,
        S_WR    = 8'b00000100,
        S_MAC   = 8'b00001000,
        S_TGT   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_MIX   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    // histogram memory and clear marks
    logic [BIN_WIDTH-1:0] hist_mem [12];
    logic [11:0]          hvalid_reg;
    logic [BIN_WIDTH-1:0] rd_reg;
    logic                 rd_ok_reg;
    logic [3:0]           raddr;

    logic [3:0]  pc_reg;
    logic [15:0] inc_reg;
    logic [3:0]  k_reg, i_reg;
    logic [3:0]  ki_reg;
    logic        vld_d_reg;
    logic [AccW-1:0] smaj_reg, smin_reg, best_reg;
    logic [3:0]  bkey_reg;
    logic        bmin_reg;
    logic [AccW-1:0] y_reg;
    logic [16:0] tgt_reg;
    logic [15:0] conf_reg;
    logic [3:0]  tonic_reg;
    logic        minor_reg;

    logic [BIN_WIDTH-1:0] bin_val;
    logic [BIN_WIDTH:0]   bin_sum;
    logic [BIN_WIDTH-1:0] bin_new;
    logic [3:0]  idx;
    logic [BIN_WIDTH+9:0] pmaj, pmin;
    logic [AccW-1:0] maj_n, min_n, best_a;
    logic [3:0]  bkey_a;
    logic        bmin_a;
    logic [AccW+16-1:0] prod;
    logic [AccW+16-1:0] ysum;
    logic [46:0] qprod;
    logic [16:0] wc;
    logic [32:0] mixv;
    logic [16:0] mixr;

    assign raddr = state_reg == S_IDLE ? pclass : (state_reg == S_RD ? pc_reg : i_reg);
    assign bin_val = rd_ok_reg ? rd_reg : '0;
    assign bin_sum = {1'b0, bin_val} + {{(BIN_WIDTH-16+1){1'b0}}, inc_reg};
    assign bin_new = bin_sum[BIN_WIDTH] ? '1 : bin_sum[BIN_WIDTH-1:0];

    // synchronous memory read and write
    always_ff @(posedge clk)
    begin
        rd_reg <= hist_mem[raddr];
        if (state_reg == S_WR)
        begin
            hist_mem[pc_reg] <= bin_new;
        end
    end

    // profile index and accumulation of the word read last cycle
    assign pmaj = {{10{1'b0}}, bin_val} * {{BIN_WIDTH{1'b0}}, major_prof(idx)};
    assign pmin = {{10{1'b0}}, bin_val} * {{BIN_WIDTH{1'b0}}, minor_prof(idx)};

    always_comb
    begin
        idx = (ki_reg >= k_reg) ? ki_reg - k_reg : ki_reg + 4'd12 - k_reg;
        maj_n = smaj_reg;
        min_n = smin_reg;
        if (vld_d_reg)
        begin
            maj_n = smaj_reg + AccW'(pmaj);
            min_n = smin_reg + AccW'(pmin);
        end
        best_a = best_reg;
        bkey_a = bkey_reg;
        bmin_a = bmin_reg;
        if (maj_n > best_a)
        begin
            best_a = maj_n;
            bkey_a = k_reg;
            bmin_a = 1'b0;
        end
        if (min_n > best_a)
        begin
            best_a = min_n;
            bkey_a = k_reg;
            bmin_a = 1'b1;
        end
    end

    // target: shift by 16, then divide by 100 through the reciprocal, rounded to nearest
    assign prod  = (AccW+16)'(best_reg) * (AccW+16)'(cfg.scale);
    assign ysum  = prod + (AccW+16)'(3276800);
    assign qprod = {24'd0, y_reg[22:0]} * {23'd0, DivM};
    assign wc    = 17'd65536 - {1'b0, cfg.weight};
    assign mixv  = {16'd0, wc} * {17'd0, conf_reg}
                 + {16'd0, 1'b0, cfg.weight} * {16'd0, tgt_reg} + 33'd32768;
    assign mixr  = mixv[32:16];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_RD;
            S_RD:    state_next = S_WR;
            S_WR:    state_next = S_MAC;
            S_MAC:   if (k_reg == 4'd11 && ki_reg == 4'd11 && vld_d_reg && i_reg == 4'd0)
                         state_next = S_TGT;
            S_TGT:   state_next = S_DIV;
            S_DIV:   state_next = S_MIX;
            S_MIX:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            hvalid_reg <= '0;
            conf_reg   <= '0;
            tonic_reg  <= '0;
            minor_reg  <= 1'b0;
            rd_ok_reg  <= 1'b0;
            vld_d_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_ok_reg <= hvalid_reg[raddr];
            case (state_reg)
                S_IDLE:
                begin
                    vld_d_reg <= 1'b0;
                    if (start)
                    begin
                        pc_reg  <= pclass;
                        inc_reg <= 16'((32'(harm) * 32'(cfg.gain) + 32'd32768) >> 16);
                    end
                end
                S_WR:
                begin
                    hvalid_reg[pc_reg] <= 1'b1;
                    k_reg    <= '0;
                    i_reg    <= '0;
                    smaj_reg <= '0;
                    smin_reg <= '0;
                    best_reg <= '0;
                    bkey_reg <= '0;
                    bmin_reg <= 1'b0;
                end
                S_MAC:
                begin
                    // issue read of bin i, accumulate previous
                    ki_reg    <= i_reg;
                    vld_d_reg <= 1'b1;
                    i_reg     <= (i_reg == 4'd11) ? 4'd0 : i_reg + 4'd1;
                    if (vld_d_reg && ki_reg == 4'd11)
                    begin
                        best_reg <= best_a;
                        bkey_reg <= bkey_a;
                        bmin_reg <= bmin_a;
                        smaj_reg <= '0;
                        smin_reg <= '0;
                        k_reg    <= k_reg + 4'd1;
                    end
                    else
                    begin
                        smaj_reg <= maj_n;
                        smin_reg <= min_n;
                    end
                end
                S_TGT:
                begin
                    y_reg <= ysum[AccW+15:16];
                end
                S_DIV:
                begin
                    // quotients from 65537 up are capped at one
                    if (cfg.scale == 16'd0)
                        tgt_reg <= '0;
                    else if (y_reg >= AccW'(6553700))
                        tgt_reg <= 17'd65536;
                    else
                        tgt_reg <= qprod[46:30];
                end
                S_MIX:
                begin
                    conf_reg  <= mixr[16] ? 16'hFFFF : mixr[15:0];
                    tonic_reg <= bkey_reg;
                    minor_reg <= bmin_reg;
                end
                default: ;
            endcase
        end
    end

    assign busy  = state_reg != S_IDLE;
    assign done  = state_reg == S_DONE;
    assign tonic = tonic_reg;
    assign minor = minor_reg;
    assign conf  = conf_reg;
endmodule

>>> rtl/core/musical_key_tracker_core.sv
// Musical key tracker top level.
// Input channel in_ch carries {pitch_hz, harmonicity_level} per frame; the
// output channel out_ch carries {pitch_class, key_tonic, key_is_minor,
// key_confidence}. A frame with zero pitch or harmonicity below threshold
// is dropped with no result. A counted frame goes from its acceptance to
// a valid result through a read-modify-write of its histogram bin, then
// 144 reads of the histogram memory (12 bins per tonic, 12 tonics), each
// feeding one major and one minor multiply-accumulate, then target,
// divide and smoothing steps. One frame is worked on at a time; a new
// word is taken while a result still waits in the output register, but
// the block does not start it until that register is free. When the
// receiver stalls, the result holds and the next counted frame stalls
// behind it. Reset clears the histogram through per-bin clear marks at
// once, sets confidence to zero, key to C major and the registers to
// their defaults. Configuration writes go through cfg_we, cfg_index and
// cfg_data.
module musical_key_tracker_core
    import mkt_pkg::*;
#(
    parameter int BIN_WIDTH = BinWidthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mkt_if.sink         in_ch,
    mkt_if.source       out_ch
);
    cfg_t cfg_reg;
    logic [39:0] in_reg;
    logic        in_full_reg;
    logic [24:0] out_reg;
    logic        out_full_reg;
    logic [3:0]  pclass;
    logic        start, busy, done, keep;
    logic [3:0]  tonic;
    logic        minor;
    logic [15:0] conf;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{ThreshReset, GainReset, ScaleReset, WeightReset};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegThresh: cfg_reg.thresh <= cfg_data;
                RegGain:   cfg_reg.gain   <= cfg_data;
                RegScale:  cfg_reg.scale  <= cfg_data;
                RegWeight: cfg_reg.weight <= cfg_data;
                default: ;
            endcase
        end
    end

    mkt_classify u_cls (.pitch(in_reg[39:16]), .pclass(pclass));

    assign keep  = (in_reg[39:16] != 24'd0) && (in_reg[15:0] >= cfg_reg.thresh);
    assign start = in_full_reg && keep && !busy && !out_full_reg;

    mkt_engine #(.BIN_WIDTH(BIN_WIDTH)) u_eng (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .start(start),
        .pclass(pclass), .harm(in_reg[15:0]), .busy(busy), .done(done),
        .tonic(tonic), .minor(minor), .conf(conf)
    );

    assign in_ch.ready = !in_full_reg;
    assign out_ch.valid = out_full_reg;
    assign out_ch.data  = out_reg;

    // input holding register and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && !in_full_reg)
            begin
                in_full_reg <= 1'b1;
                in_reg      <= in_ch.data;
            end
            else if (in_full_reg && (!keep || start))
            begin
                in_full_reg <= 1'b0;
            end
            if (start)
            begin
                out_reg[24:21] <= pclass;
            end
            if (done)
            begin
                out_full_reg   <= 1'b1;
                out_reg[20:0]  <= {tonic, minor, conf};
            end
            else if (out_ch.ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end
endmodule
